/* src/alti_pkg.sv */
// ----------------------------------------------------------------------------
// alti_pkg
// Types and constants for the arc length table interpolator.
// ----------------------------------------------------------------------------
package alti_pkg;

  localparam logic [1:0] CMD_LOAD      = 2'd0;
  localparam logic [1:0] CMD_PARAM_LEN = 2'd1;
  localparam logic [1:0] CMD_LEN_PARAM = 2'd2;
  localparam logic [1:0] CMD_PARAM_FRC = 2'd3;

  localparam int unsigned CFG_IDX_W    = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH   = 1'd1;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
  localparam int unsigned PARAM_W      = 17;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned DIV_CNT_W    = 5;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  entry_index;
    logic [16:0] entry_parameter;
    logic [31:0] entry_arc_length;
    logic [31:0] query_value;
  } req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        status;
  } rsp_t;

endpackage

/* src/arc_length_table_interpolator.sv */
// ----------------------------------------------------------------------------
// arc_length_table_interpolator
// Table of curve parameter / arc length pairs with binary search lookup and
// linear interpolation through one shared multiplier and a serial divider.
//
//   port group              dir  handshake
//   request / start / busy  in   taken when start & !busy
//   response / done         out  valid for the single cycle done is high
//   cfg_we/cfg_index/data   in   written when cfg_we is high
//
// A load writes the table without raising busy. A lookup runs the probe and
// compare states per binary search probe (one table read each, up to 9
// probes), the fetch, high and low states for the segment, one multiply and
// 32 divider steps (less if clamped/empty). Busy is high for the whole lookup.
// Reset clears the sequencer and the configuration registers; the table
// holds garbage until loaded. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module arc_length_table_interpolator #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  alti_pkg::req_t                        request,
  output logic                                  done,
  output alti_pkg::rsp_t                        response,
  input  logic                                  cfg_we,
  input  logic [alti_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [alti_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int WORD_W = alti_pkg::PARAM_W + alti_pkg::LEN_W;
  localparam logic [alti_pkg::CFG_IDX_W-1:0] REG_SEL_ENTRIES = alti_pkg::REG_ENTRIES_IN_USE;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SCALE = 11'b000_0000_0010,
    S_CLAMP = 11'b000_0000_0100,
    S_PROBE = 11'b000_0000_1000,
    S_CMP   = 11'b000_0001_0000,
    S_FETCH = 11'b000_0010_0000,
    S_HI    = 11'b000_0100_0000,
    S_LO    = 11'b000_1000_0000,
    S_MUL   = 11'b001_0000_0000,
    S_DIV   = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [8:0]  entries_in_use;
  logic [31:0] total_length;

  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;

  logic          by_param;
  logic [31:0]   key;
  logic [CW-1:0] lo;
  logic [CW-1:0] count;
  logic [CW-1:0] step;
  logic [CW-1:0] n_used;
  logic [31:0]   hk;
  logic [31:0]   hv;
  logic [31:0]   lv;
  logic          neg;
  logic [31:0]   mag;
  logic [31:0]   diff;
  logic [31:0]   den;
  logic [31:0]   rem;
  logic [31:0]   quo;
  logic [alti_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [31:0] rd_key;
  logic [31:0] rd_val;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [32:0] trial;

  assign busy = (state != S_IDLE);
  assign step = count >> 1;

  always_comb begin
    if (32'(entries_in_use) > TABLE_DEPTH) begin
      n_used = CW'(TABLE_DEPTH);
    end else begin
      n_used = CW'(entries_in_use);
    end
  end

  // word layout: {parameter, arc length}
  always_comb begin
    if (by_param) begin
      rd_key = 32'(rd_data[WORD_W-1:alti_pkg::LEN_W]);
      rd_val = rd_data[alti_pkg::LEN_W-1:0];
    end else begin
      rd_key = rd_data[alti_pkg::LEN_W-1:0];
      rd_val = 32'(rd_data[WORD_W-1:alti_pkg::LEN_W]);
    end
  end

  always_comb begin
    unique case (state)
      S_PROBE: rd_addr = AW'(lo + step);
      S_FETCH: rd_addr = (lo >= n_used) ? AW'(n_used - CW'(1)) : AW'(lo);
      default: rd_addr = AW'(lo - CW'(1));
    endcase
  end

  // shared multiplier: fraction scaling or interpolation numerator
  always_comb begin
    if (state == S_SCALE) begin
      mul_a = key;
      mul_b = total_length;
    end else begin
      mul_a = mag;
      mul_b = diff;
    end
    prod = 64'(mul_a) * 64'(mul_b);
  end

  assign trial = {rem, quo[31]} - {1'b0, den};

  assign mem_we = start && !busy && (request.command == alti_pkg::CMD_LOAD) &&
                  (32'(request.entry_index) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(request.entry_index)] <= {request.entry_parameter, request.entry_arc_length};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      entries_in_use <= '0;
      total_length   <= '0;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEL_ENTRIES: entries_in_use <= cfg_data[8:0];
          default:         total_length   <= cfg_data;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            key      <= request.query_value;
            by_param <= (request.command == alti_pkg::CMD_LEN_PARAM);
            lo       <= '0;
            count    <= n_used;
            response <= '{result_value: 32'd0, status: 1'b0};
            if (request.command == alti_pkg::CMD_LOAD) begin
              done <= 1'b1;
            end else if (n_used < CW'(2)) begin
              done     <= 1'b1;
              response <= '{result_value: 32'd0, status: 1'b1};
            end else if (request.command == alti_pkg::CMD_PARAM_LEN) begin
              state <= S_CLAMP;
            end else if (request.query_value == 32'd0) begin
              done <= 1'b1;
            end else if (request.query_value >= alti_pkg::ONE_Q16) begin
              done <= 1'b1;
              if (request.command == alti_pkg::CMD_LEN_PARAM) begin
                response.result_value <= total_length;
              end else begin
                response.result_value <= alti_pkg::ONE_Q16;
              end
            end else if (request.command == alti_pkg::CMD_LEN_PARAM) begin
              state <= S_PROBE;
            end else begin
              state <= S_SCALE;
            end
          end
        end

        S_SCALE: begin
          key   <= prod[47:16];
          state <= S_CLAMP;
        end

        S_CLAMP: begin
          if (key == 32'd0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (key >= total_length) begin
            response.result_value <= alti_pkg::ONE_Q16;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_PROBE;
          end
        end

        S_PROBE: begin
          if (count == '0) begin
            state <= S_FETCH;
          end else begin
            state <= S_CMP;
          end
        end

        S_CMP: begin
          if (rd_key < key) begin
            lo    <= lo + step + CW'(1);
            count <= count - step - CW'(1);
          end else begin
            count <= step;
          end
          state <= S_PROBE;
        end

        S_FETCH: begin
          state <= S_HI;
        end

        S_HI: begin
          hk <= rd_key;
          hv <= rd_val;
          if (lo >= n_used || lo == '0) begin
            response.result_value <= rd_val;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_LO;
          end
        end

        S_LO: begin
          lv   <= rd_val;
          neg  <= (hv < rd_val);
          mag  <= (hv < rd_val) ? (rd_val - hv) : (hv - rd_val);
          diff <= key - rd_key;
          den  <= hk - rd_key;
          if (hk <= rd_key) begin
            response.result_value <= rd_val;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_MUL;
          end
        end

        S_MUL: begin
          rem     <= prod[63:32];
          quo     <= prod[31:0];
          div_cnt <= '0;
          state   <= S_DIV;
        end

        S_DIV: begin
          if (!trial[32]) begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
          div_cnt <= div_cnt + alti_pkg::DIV_CNT_W'(1);
          if (div_cnt == alti_pkg::DIV_CNT_W'(alti_pkg::DIV_STEPS - 1)) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          response.result_value <= neg ? (lv - quo) : (lv + quo);
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
